// ===== rtl/bdc_pkg.sv =====
// shared types and constants for the signed binary to decimal ascii converter
package bdc_pkg;

   // stream payload widths
   localparam int unsigned REQ_DATA_WIDTH = 64;
   localparam int unsigned RSP_DATA_WIDTH = 8;
   localparam int unsigned CHAR_WIDTH     = 6;
   localparam int unsigned DIGIT_WIDTH    = 4;

   // ascii codes, trimmed to the character field
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

   // what every digit cell does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_DABBLE,
      CELL_MOVE
   } cell_mode_type;

endpackage

// ===== rtl/signed_binary_to_decimal_ascii.sv =====
// signed binary to decimal ascii converter, top level
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata[63:0] value
//  rsp     | out       | rsp_tvalid/tready    | tdata[5:0] char_code, tlast last
//
// one request is loaded, then its magnitude is shifted through the digit cell chain
// by double dabble, one magnitude bit per cycle; then leading zeros are skipped,
// one per cycle, and the characters are sent (sign first). a new request is taken
// only once the last character of the previous one is in the result register.
// reset clears the controller and the result register; the cells are cleared on
// load. a stalled result side holds the current character and pauses emission.
module signed_binary_to_decimal_ascii #(
   parameter int unsigned VALUE_WIDTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bdc_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,   // [63:0] value
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bdc_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,   // [5:0] char_code, [7:6] zero
   output logic                                  rsp_tlast
);

   // digits needed for the largest magnitude, 2 to the power VALUE_WIDTH-1
   localparam int unsigned DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);
   localparam int unsigned IDX_W  = $clog2(DIGITS + 1);
   localparam int unsigned DW     = bdc_pkg::DIGIT_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   state_type                          state_ff;
   logic [CNT_W-1:0]                   bit_cnt_ff;
   logic [VALUE_WIDTH-1:0]             mag_ff;
   logic [IDX_W-1:0]                   remain_ff;
   logic                               started_ff;
   logic                               rsp_valid_ff;
   logic [bdc_pkg::CHAR_WIDTH-1:0]     rsp_char_ff;
   logic                               rsp_last_ff;

   logic [VALUE_WIDTH-1:0]             raw;
   logic [VALUE_WIDTH-1:0]             magnitude;
   logic                               slot_free;
   logic                               skip;
   logic                               emit;
   logic [DW-1:0]                      top_digit;
   bdc_pkg::cell_mode_type             cell_mode;
   logic [DIGITS-1:0][DW-1:0]          digit;
   logic [DIGITS:0]                    carry;

   // magnitude of the incoming value
   assign raw       = req_tdata[VALUE_WIDTH-1:0];
   assign magnitude = raw[VALUE_WIDTH-1] ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

   assign req_tready = (state_ff == ST_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign top_digit  = digit[DIGITS-1];

   // leading zeros are dropped, the last digit never
   assign skip = (state_ff == ST_DIGITS) && !started_ff && (top_digit == '0)
                 && (remain_ff != IDX_W'(1));

   // a new character goes into the result register
   assign emit = slot_free && ((state_ff == ST_SIGN) || ((state_ff == ST_DIGITS) && !skip));

   // cell chain control
   always_comb begin
      unique case (state_ff)
         ST_IDLE:    cell_mode = req_tvalid ? bdc_pkg::CELL_CLEAR : bdc_pkg::CELL_HOLD;
         ST_CONVERT: cell_mode = bdc_pkg::CELL_DABBLE;
         ST_SIGN:    cell_mode = bdc_pkg::CELL_HOLD;
         ST_DIGITS:  cell_mode = (skip || slot_free) ? bdc_pkg::CELL_MOVE
                                                     : bdc_pkg::CELL_HOLD;
      endcase
   end

   // digit cell chain, least significant digit in cell 0
   assign carry[0] = mag_ff[VALUE_WIDTH-1];

   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      logic [DW-1:0] lower_digit;

      if (i == 0) begin : g_first
         assign lower_digit = '0;
      end else begin : g_rest
         assign lower_digit = digit[i-1];
      end

      bdc_cell u_cell (
         .clock     (clock),
         .mode      (cell_mode),
         .bit_in    (carry[i]),
         .digit_in  (lower_digit),
         .digit     (digit[i]),
         .carry_out (carry[i+1])
      );
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         mag_ff       <= '0;
         remain_ff    <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_char_ff  <= '0;
         rsp_last_ff  <= 1'b0;
      end else begin
         // result valid rises with a new character and drops once taken
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  mag_ff     <= magnitude;
                  started_ff <= raw[VALUE_WIDTH-1];
                  bit_cnt_ff <= CNT_W'(VALUE_WIDTH);
                  state_ff   <= ST_CONVERT;
               end
            end
            ST_CONVERT: begin
               mag_ff     <= {mag_ff[VALUE_WIDTH-2:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff - CNT_W'(1);
               if (bit_cnt_ff == CNT_W'(1)) begin
                  remain_ff  <= IDX_W'(DIGITS);
                  started_ff <= 1'b0;
                  // started_ff carried the sign through conversion
                  state_ff   <= started_ff ? ST_SIGN : ST_DIGITS;
               end
            end
            ST_SIGN: begin
               if (slot_free) begin
                  rsp_char_ff  <= bdc_pkg::CHAR_MINUS;
                  rsp_last_ff  <= 1'b0;
                  state_ff     <= ST_DIGITS;
               end
            end
            ST_DIGITS: begin
               if (skip) begin
                  remain_ff <= remain_ff - IDX_W'(1);
               end else if (slot_free) begin
                  rsp_char_ff  <= bdc_pkg::CHAR_ZERO + {2'b00, top_digit};
                  rsp_last_ff  <= (remain_ff == IDX_W'(1));
                  remain_ff    <= remain_ff - IDX_W'(1);
                  started_ff   <= 1'b1;
                  if (remain_ff == IDX_W'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bdc_pkg::RSP_DATA_WIDTH - bdc_pkg::CHAR_WIDTH){1'b0}}, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/bdc_cell.sv =====
// one decimal digit cell of the double dabble chain
module bdc_cell (
   input  logic                                 clock,
   input  bdc_pkg::cell_mode_type               mode,
   input  logic                                 bit_in,
   input  logic [bdc_pkg::DIGIT_WIDTH-1:0]      digit_in,
   output logic [bdc_pkg::DIGIT_WIDTH-1:0]      digit,
   output logic                                 carry_out
);

   logic [bdc_pkg::DIGIT_WIDTH-1:0] digit_ff;
   logic [bdc_pkg::DIGIT_WIDTH-1:0] digit_in_next;
   logic [bdc_pkg::DIGIT_WIDTH-1:0] adjusted;

   // add three when the digit would overflow on doubling
   assign adjusted  = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
   assign carry_out = adjusted[bdc_pkg::DIGIT_WIDTH-1];

   // next digit per mode
   always_comb begin
      unique case (mode)
         bdc_pkg::CELL_HOLD:   digit_in_next = digit_ff;
         bdc_pkg::CELL_CLEAR:  digit_in_next = '0;
         bdc_pkg::CELL_DABBLE: digit_in_next = {adjusted[bdc_pkg::DIGIT_WIDTH-2:0], bit_in};
         bdc_pkg::CELL_MOVE:   digit_in_next = digit_in;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

   assign digit = digit_ff;

endmodule

// ===== verif/tb_signed_binary_to_decimal_ascii.sv =====
// testbench for the signed binary to decimal ascii converter: directed and random values
`timescale 1ns / 100ps

module tb_signed_binary_to_decimal_ascii;

   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned DRAIN_LIMIT  = 20000;
   localparam int unsigned SETTLE_TICKS = 120;

   // one character of the decimal text
   typedef struct packed {
      logic [bdc_pkg::CHAR_WIDTH-1:0] char_code;
      logic                           last;
   } text_char_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [bdc_pkg::REQ_DATA_WIDTH-1:0] req_tdata  = '0;    // [63:0] value
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [bdc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;          // [5:0] char_code, [7:6] zero
   logic                               rsp_tlast;

   text_char_type expected_chars[$];
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned values_sent        = 0;
   int unsigned negatives_sent     = 0;
   int unsigned chars_checked      = 0;
   int unsigned error_count        = 0;
   int unsigned reported_errors    = 0;

   signed_binary_to_decimal_ascii #(
      .VALUE_WIDTH(64)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   always #1 clock = ~clock;

   // works out the decimal text of one value and queues its characters
   function automatic void predict_decimal_text(input logic [63:0] value);
      logic [63:0]   magnitude;
      logic [63:0]   remainder;
      logic [3:0]    digits [20];
      int            n_digits;
      int            n_chars;
      int            pos;
      text_char_type ch;
      magnitude = value[63] ? (~value + 64'd1) : value;
      n_digits  = 0;
      do begin
         remainder        = magnitude % 64'd10;
         digits[n_digits] = remainder[3:0];
         magnitude        = magnitude / 64'd10;
         n_digits++;
      end while (magnitude != 64'd0);
      n_chars = n_digits + (value[63] ? 1 : 0);
      pos     = 0;
      if (value[63]) begin
         ch.char_code = bdc_pkg::CHAR_MINUS;
         ch.last      = (n_chars == 1);
         expected_chars.push_back(ch);
         pos++;
      end
      for (int i = n_digits - 1; i >= 0; i--) begin
         ch.char_code = bdc_pkg::CHAR_ZERO + {2'b00, digits[i]};
         ch.last      = (pos == n_chars - 1);
         expected_chars.push_back(ch);
         pos++;
      end
   endfunction

   // sends one request, idling first at random, and predicts its text once accepted
   task automatic send_value(input logic [63:0] value);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_decimal_text(value);
      values_sent++;
      if (value[63]) negatives_sent++;
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // compares each accepted character with the oldest expectation
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            error_count++;
            if (reported_errors < MAX_REPORTS) begin
               reported_errors++;
               $display("ERROR: unexpected character code %0d last %0b",
                        rsp_tdata[bdc_pkg::CHAR_WIDTH-1:0], rsp_tlast);
            end
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_tdata[bdc_pkg::CHAR_WIDTH-1:0] !== want.char_code
                || rsp_tlast !== want.last) begin
               error_count++;
               if (reported_errors < MAX_REPORTS) begin
                  reported_errors++;
                  $display("ERROR: char %0d: expected code %0d last %0b, got code %0d last %0b",
                           chars_checked, want.char_code, want.last,
                           rsp_tdata[bdc_pkg::CHAR_WIDTH-1:0], rsp_tlast);
               end
            end
         end
      end
   end

   // extremes, sign handling, zero and digit-count boundaries
   task automatic test_directed_values();
      logic [63:0] directed [$];
      directed = '{64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, -64'd10, 64'd99, 64'd100,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                   64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE,
                   64'd1000000000000000000, 64'd999999999999999999,
                   -64'd1000000000000000000, 64'd1234567890123456789,
                   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                   64'd4294967296, -64'd4294967295};
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      foreach (directed[i]) send_value(directed[i]);
   endtask

   // random values of mixed size under one idling pattern
   task automatic test_random_values(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
      logic [63:0] value;
      logic [63:0] power;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) begin
         case ($urandom_range(3))
            0: value = {$urandom, $urandom};
            1: value = 64'($urandom_range(1000));
            2: value = {$urandom, $urandom} >> $urandom_range(63);
            default: begin
               power = 64'd1;
               repeat ($urandom_range(18)) power = power * 64'd10;
               value = power - 64'd1 + 64'($urandom_range(1));
            end
         endcase
         if ($urandom_range(1) == 1) value = ~value + 64'd1;
         send_value(value);
      end
   endtask

   // waits for every expected character or until the drain limit, then lets the block settle
   task automatic wait_for_drain();
      int unsigned ticks;
      req_tvalid <= 1'b0;
      ticks = 0;
      while (expected_chars.size() != 0 && ticks < DRAIN_LIMIT) begin
         @(posedge clock);
         ticks++;
      end
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // test sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_values();
      test_random_values(0, 0, 70);
      test_random_values(76, 0, 80);
      test_random_values(0, 76, 80);
      test_random_values(7, 7, 60);
      wait_for_drain();
      if (expected_chars.size() != 0) begin
         error_count += expected_chars.size();
         $display("ERROR: %0d characters never arrived", expected_chars.size());
      end
      $display("converted %0d values (%0d negative), checked %0d characters",
               values_sent, negatives_sent, chars_checked);
      $display("idling phases: none, sender gaps, result stalls, both; %0d errors",
               error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("ERROR: run timed out");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/bdc_pkg.sv
rtl/bdc_cell.sv
rtl/signed_binary_to_decimal_ascii.sv
verif/tb_signed_binary_to_decimal_ascii.sv
